/* hdl/mctm_pkg.sv */
// Package for the multichannel trimmed-mean filter: field widths, command codes,
// the per-slot state word kept in the state memory, and its reset value.
// No dependencies.
package mctm_pkg;

    localparam int SLOTS     = 16;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 4;
    localparam int SAMPLE_W  = 10;
    localparam int TARGET_W  = 6;
    localparam int SUM_W     = 16;
    localparam int LOW_W     = 11;
    localparam int DELAY_W   = 16;
    localparam int DIV_STEPS = SUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [CMD_W-1:0] CMD_SAMPLE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENABLE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISABLE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONFIGURE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

    localparam logic [LOW_W-1:0]    MIN_RESET    = 11'd1024;
    localparam logic [SAMPLE_W-1:0] MAX_RESET    = 10'd0;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 6'd52;
    localparam logic [TARGET_W-1:0] TARGET_FLOOR = 6'd3;
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = 16'd1000;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [TARGET_W-1:0] count;
        logic [LOW_W-1:0]    lowest;
        logic [SAMPLE_W-1:0] highest;
        logic [SAMPLE_W-1:0] average;
        logic                enabled;
        logic [TARGET_W-1:0] target;
        logic                has_delay;
        logic [DELAY_W-1:0]  delay_left;
    } slot_state_t;

    localparam slot_state_t SLOT_RESET = '{
        sum:        '0,
        count:      '0,
        lowest:     MIN_RESET,
        highest:    MAX_RESET,
        average:    '0,
        enabled:    1'b1,
        target:     TARGET_RESET,
        has_delay:  1'b0,
        delay_left: '0
    };

endpackage

/* hdl/multichannel_trimmed_mean_filter.sv */
// Top level of the multichannel trimmed-mean filter: command decode, per-slot state
// memory, serial divider and output register.
// Depends on mctm_pkg.
//
// Each accepted word reads its slot's state from a one-port 16-entry state memory
// (registered read), updates it in the following cycle, and writes it back
// together with loading the result register. A sample tick that completes an
// average also passes through the restoring divider that works out the trimmed
// sum over target minus two, one quotient bit a cycle. Reset values of the slots
// come from one valid flip-flop per entry, so no clearing pass is needed. A new
// word is taken while the previous result still waits in the output register.
module multichannel_trimmed_mean_filter
    import mctm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [DELAY_W-1:0]  cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic [TARGET_W-1:0] s_sample_target,
    input  logic                s_uses_delay,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [SLOT_W-1:0]   m_out_slot,
    output logic [SAMPLE_W-1:0] m_average,
    output logic                m_fresh,
    output logic                m_settling
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [DELAY_W-1:0]  settle_delay_reg;

    slot_state_t         mem [SLOTS];
    slot_state_t         rd_data_reg;
    logic [SLOTS-1:0]    valid_reg;

    logic [CMD_W-1:0]    cmd_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [TARGET_W-1:0] target_in_reg;
    logic                uses_delay_reg;

    slot_state_t         work_reg;
    logic                fresh_reg;
    logic                settling_reg;
    logic [SUM_W-1:0]    dvd_reg;
    logic [TARGET_W-1:0] rem_reg;
    logic [TARGET_W-1:0] divisor_reg;
    logic [DCNT_W-1:0]   div_cnt_reg;

    logic                m_valid_reg;
    logic [SLOT_W-1:0]   m_out_slot_reg;
    logic [SAMPLE_W-1:0] m_average_reg;
    logic                m_fresh_reg;
    logic                m_settling_reg;

    logic                s_accept;
    logic                in_range;
    logic                out_free;
    logic                mem_we;
    slot_state_t         cur;
    slot_state_t         upd;
    logic                upd_fresh;
    logic                upd_settling;
    logic [SUM_W-1:0]    upd_trimmed;
    logic [SUM_W-1:0]    sum_new;
    logic [TARGET_W-1:0] count_new;
    logic [LOW_W-1:0]    low_new;
    logic [SAMPLE_W-1:0] high_new;
    logic [TARGET_W:0]   div_trial;
    logic                div_take;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign in_range = ({1'b0, slot_reg} < (SLOT_W + 1)'(SLOTS));
    assign out_free = !m_valid_reg || m_ready;
    assign mem_we   = (state_reg == ST_DONE) && out_free && in_range;

    // Entries that were never written read as their reset value.
    assign cur = valid_reg[slot_reg[IDX_W-1:0]] ? rd_data_reg : SLOT_RESET;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= mem[s_slot[IDX_W-1:0]];
        end
        if (mem_we) begin
            mem[slot_reg[IDX_W-1:0]] <= work_reg;
        end
    end

    // Slot update, evaluated in the cycle after the memory read.
    always_comb begin
        upd          = cur;
        upd_fresh    = 1'b0;
        upd_settling = 1'b0;
        upd_trimmed  = '0;
        sum_new      = cur.sum + SUM_W'(sample_reg);
        count_new    = cur.count + TARGET_W'(1);
        low_new      = ({1'b0, sample_reg} < cur.lowest) ? {1'b0, sample_reg} : cur.lowest;
        high_new     = (sample_reg > cur.highest) ? sample_reg : cur.highest;
        if (in_range) begin
            case (cmd_reg)
                CMD_SAMPLE: begin
                    if (!cur.enabled) begin
                        if (cur.has_delay) begin
                            upd.delay_left = settle_delay_reg;
                        end
                        upd.sum     = '0;
                        upd.count   = '0;
                        upd.lowest  = MIN_RESET;
                        upd.highest = MAX_RESET;
                    end else if (cur.has_delay && (cur.delay_left != '0)) begin
                        upd.delay_left = cur.delay_left - DELAY_W'(1);
                        upd_settling   = 1'b1;
                    end else if (cur.count < cur.target) begin
                        upd.sum     = sum_new;
                        upd.count   = count_new;
                        upd.lowest  = low_new;
                        upd.highest = high_new;
                        if (count_new == cur.target) begin
                            upd_fresh   = 1'b1;
                            upd_trimmed = sum_new - (SUM_W'(low_new) + SUM_W'(high_new));
                            upd.sum     = '0;
                            upd.count   = '0;
                            upd.lowest  = MIN_RESET;
                            upd.highest = MAX_RESET;
                        end
                    end
                end
                CMD_ENABLE: begin
                    upd.enabled = 1'b1;
                end
                CMD_DISABLE: begin
                    upd.enabled = 1'b0;
                    if (cur.has_delay) begin
                        upd.delay_left = settle_delay_reg;
                    end
                    upd.sum     = '0;
                    upd.count   = '0;
                    upd.lowest  = MIN_RESET;
                    upd.highest = MAX_RESET;
                end
                CMD_CONFIGURE: begin
                    upd.target     = (target_in_reg < TARGET_FLOOR) ? TARGET_FLOOR
                                                                    : target_in_reg;
                    upd.has_delay  = uses_delay_reg;
                    upd.delay_left = uses_delay_reg ? settle_delay_reg : '0;
                    upd.sum        = '0;
                    upd.count      = '0;
                    upd.lowest     = MIN_RESET;
                    upd.highest    = MAX_RESET;
                end
                default: begin
                    upd = cur;
                end
            endcase
        end
    end

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign div_trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign div_take  = (div_trial >= {1'b0, divisor_reg});

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = upd_fresh ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            settle_delay_reg <= DELAY_RESET;
            valid_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                settle_delay_reg <= cfg_wr_data;
            end
            if (mem_we) begin
                valid_reg[slot_reg[IDX_W-1:0]] <= 1'b1;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg        <= s_command;
            slot_reg       <= s_slot;
            sample_reg     <= s_sample;
            target_in_reg  <= s_sample_target;
            uses_delay_reg <= s_uses_delay;
        end
        case (state_reg)
            ST_READ: begin
                work_reg     <= upd;
                fresh_reg    <= upd_fresh;
                settling_reg <= upd_settling;
                dvd_reg      <= upd_trimmed;
                rem_reg      <= '0;
                divisor_reg  <= cur.target - TARGET_W'(2);
                div_cnt_reg  <= '0;
            end
            ST_DIV: begin
                rem_reg     <= div_take ? TARGET_W'(div_trial - {1'b0, divisor_reg})
                                        : div_trial[TARGET_W-1:0];
                dvd_reg     <= {dvd_reg[SUM_W-2:0], div_take};
                div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    work_reg.average <= {dvd_reg[SAMPLE_W-2:0], div_take};
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_out_slot_reg <= slot_reg;
                    m_average_reg  <= in_range ? work_reg.average : '0;
                    m_fresh_reg    <= fresh_reg;
                    m_settling_reg <= settling_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_out_slot = m_out_slot_reg;
    assign m_average  = m_average_reg;
    assign m_fresh    = m_fresh_reg;
    assign m_settling = m_settling_reg;

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_READ))
        else $error("accepted word did not start a memory read");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) && (div_cnt_reg == DCNT_W'(DIV_STEPS - 1))
        |=> (state_reg == ST_DONE))
        else $error("divider did not finish after its last step");

    a_fresh_only_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && fresh_reg |-> $past(state_reg == ST_DIV)
        || $past(state_reg == ST_DONE))
        else $error("fresh average reached write-back without division");

    a_fresh_excl_settling: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_fresh_reg && m_settling_reg))
        else $error("result marked both fresh and settling");

    a_write_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (state_reg == ST_IDLE) && m_valid_reg)
        else $error("state write-back not paired with a result");

endmodule
